[rtl/crc_framed_record_writer_macros.svh]
// ----------------------------------------------------------------------------
// Record writer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CRC_FRAMED_RECORD_WRITER_MACROS_SVH
`define CRC_FRAMED_RECORD_WRITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFRW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be true.
`define CFRW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[rtl/crc_frw_pkg.sv]
// ----------------------------------------------------------------------------
// Record writer package
// Widths, CRC constants, command format and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
package crc_frw_pkg;

  localparam int OFFSET_BITS = 48;
  localparam int OUT_OFS_W   = 48;
  localparam int KLEN_W      = 16;
  localparam int VLEN_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int CRC_W       = 32;
  localparam int POS_W       = 4;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_KEY   = 3'b010,
    PH_VALUE = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    CMD_ERR  = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_DATA = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [BYTE_W-1:0]     byte0;
    logic [BYTE_W-1:0]     byte1;
    logic [VLEN_W-1:0]     vlen;
    logic                  do_vlen;
    logic                  do_crc;
    logic [OUT_OFS_W-1:0]  rec_ofs;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/crc_frw_in_if.sv]
// ----------------------------------------------------------------------------
// Record writer input channel
// Header and payload items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface crc_frw_in_if import crc_frw_pkg::*;;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KLEN_W-1:0] key_length;
  logic [VLEN_W-1:0] value_length;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, req_type, key_length, value_length, data_byte,
                  input ready);
  modport sink (input valid, req_type, key_length, value_length, data_byte,
                output ready);
endinterface

[rtl/crc_frw_out_if.sv]
// ----------------------------------------------------------------------------
// Record writer output channel
// Serialized record bytes with status flags and a valid/ready handshake.
// ----------------------------------------------------------------------------
interface crc_frw_out_if import crc_frw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    out_byte;
  logic                 byte_valid;
  logic                 last_in_run;
  logic                 record_done;
  logic [OUT_OFS_W-1:0] record_offset;
  logic                 error;

  modport source (output valid, out_byte, byte_valid, last_in_run, record_done,
                  record_offset, error, input ready);
  modport sink (input valid, out_byte, byte_valid, last_in_run, record_done,
                record_offset, error, output ready);
endinterface

[rtl/crc_frw_cfg_if.sv]
// ----------------------------------------------------------------------------
// Record writer configuration channel
// Write channel for the base offset register.
// ----------------------------------------------------------------------------
interface crc_frw_cfg_if import crc_frw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OUT_OFS_W-1:0] base_offset;

  modport source (output valid, base_offset, input ready);
  modport sink (input valid, base_offset, output ready);
endinterface

[rtl/crc_frw_front.sv]
// ----------------------------------------------------------------------------
// Record writer front end
// Checks item order, tracks record lengths and offsets, and issues commands.
// ----------------------------------------------------------------------------
module crc_frw_front import crc_frw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  crc_frw_in_if.sink      in_ch,
  crc_frw_cfg_if.sink     cfg_ch,
  input  logic            q_full,
  output q_wr_t           q_wr
);

  phase_t                 phase_r, phase_nxt;
  logic [KLEN_W-1:0]      key_rem_r, key_rem_nxt;
  logic [VLEN_W-1:0]      val_rem_r, val_rem_nxt;
  logic [VLEN_W-1:0]      held_vlen_r, held_vlen_nxt;
  logic [OFFSET_BITS-1:0] tail_r, tail_nxt;
  logic [OFFSET_BITS-1:0] rec_start_r, rec_start_nxt;
  logic                   accept;
  logic                   is_key;
  logic                   is_val;
  logic                   is_idle;
  logic [POS_W-1:0]       inc;
  logic [KLEN_W-1:0]      key_dec;
  logic [VLEN_W-1:0]      val_dec;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign key_dec      = key_rem_r - KLEN_W'(1);
  assign val_dec      = val_rem_r - VLEN_W'(1);

  always_comb begin
    is_key = 1'b0;
    is_val = 1'b0;
    case (phase_r)
      PH_KEY:   is_key = 1'b1;
      PH_VALUE: is_val = 1'b1;
      default:  is_key = 1'b0;
    endcase
    is_idle = !is_key && !is_val;
  end

  always_comb begin
    phase_nxt     = is_idle ? PH_IDLE : phase_r;
    key_rem_nxt   = key_rem_r;
    val_rem_nxt   = val_rem_r;
    held_vlen_nxt = held_vlen_r;
    rec_start_nxt = rec_start_r;
    inc           = '0;
    q_wr          = '0;
    q_wr.cmd.op   = CMD_ERR;
    if (accept) begin
      q_wr.push = 1'b1;
      if (!in_ch.req_type) begin
        if (!is_idle) begin
          q_wr.cmd.rec_ofs = OUT_OFS_W'(rec_start_r);
        end else begin
          q_wr.cmd.op      = CMD_HDR;
          q_wr.cmd.byte0   = in_ch.key_length[7:0];
          q_wr.cmd.byte1   = in_ch.key_length[15:8];
          q_wr.cmd.vlen    = in_ch.value_length;
          q_wr.cmd.rec_ofs = OUT_OFS_W'(tail_r);
          rec_start_nxt    = tail_r;
          held_vlen_nxt    = in_ch.value_length;
          inc              = POS_W'(2);
          if (in_ch.key_length == '0) begin
            q_wr.cmd.do_vlen = 1'b1;
            inc              = POS_W'(6);
            if (in_ch.value_length == '0) begin
              q_wr.cmd.do_crc = 1'b1;
              inc             = POS_W'(10);
              phase_nxt       = PH_IDLE;
            end else begin
              val_rem_nxt = in_ch.value_length;
              phase_nxt   = PH_VALUE;
            end
          end else begin
            key_rem_nxt = in_ch.key_length;
            phase_nxt   = PH_KEY;
          end
        end
      end else if (is_idle) begin
        q_wr.cmd.rec_ofs = OUT_OFS_W'(tail_r);
      end else begin
        q_wr.cmd.op      = CMD_DATA;
        q_wr.cmd.byte0   = in_ch.data_byte;
        q_wr.cmd.vlen    = held_vlen_r;
        q_wr.cmd.rec_ofs = OUT_OFS_W'(rec_start_r);
        inc              = POS_W'(1);
        if (is_key) begin
          key_rem_nxt = key_dec;
          if (key_dec == '0) begin
            q_wr.cmd.do_vlen = 1'b1;
            inc              = POS_W'(5);
            if (held_vlen_r == '0) begin
              q_wr.cmd.do_crc = 1'b1;
              inc             = POS_W'(9);
              phase_nxt       = PH_IDLE;
            end else begin
              val_rem_nxt = held_vlen_r;
              phase_nxt   = PH_VALUE;
            end
          end
        end else begin
          val_rem_nxt = val_dec;
          if (val_dec == '0) begin
            q_wr.cmd.do_crc = 1'b1;
            inc             = POS_W'(5);
            phase_nxt       = PH_IDLE;
          end
        end
      end
    end
    tail_nxt = tail_r + OFFSET_BITS'(inc);
    if (cfg_ch.valid && cfg_ch.ready) begin
      tail_nxt = OFFSET_BITS'(cfg_ch.base_offset);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      key_rem_r   <= '0;
      val_rem_r   <= '0;
      held_vlen_r <= '0;
      tail_r      <= '0;
      rec_start_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      key_rem_r   <= key_rem_nxt;
      val_rem_r   <= val_rem_nxt;
      held_vlen_r <= held_vlen_nxt;
      tail_r      <= tail_nxt;
      rec_start_r <= rec_start_nxt;
    end
  end

endmodule

[rtl/crc_frw_queue.sv]
// ----------------------------------------------------------------------------
// Record writer command queue
// Small first-in first-out buffer between the front end and the byte engine.
// ----------------------------------------------------------------------------
module crc_frw_queue import crc_frw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  q_full,
  output q_rd_t q_rd,
  input  logic  q_pop
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.cmd   = mem_r[rd_ptr_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/crc_frw_back.sv]
// ----------------------------------------------------------------------------
// Record writer byte engine
// Expands commands into record bytes, runs the CRC-32 and drives the output.
// ----------------------------------------------------------------------------
module crc_frw_back import crc_frw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  q_rd_t        q_rd,
  output logic         q_pop,
  crc_frw_out_if.source out_ch
);

  cmd_t                 c;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [CRC_W-1:0]     crc_r, crc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 byte_valid_r;
  logic                 last_r;
  logic                 done_r;
  logic [OUT_OFS_W-1:0] ofs_r;
  logic                 err_r;
  logic [POS_W-1:0]     seg_a;
  logic [POS_W-1:0]     total;
  logic [POS_W-1:0]     rel_v;
  logic [POS_W-1:0]     rel_c;
  logic                 in_a;
  logic                 in_v;
  logic                 in_c;
  logic                 last;
  logic                 fire;
  logic                 is_err;
  logic [CRC_W-1:0]     crc_out;
  logic [CRC_W-1:0]     crc_base;
  logic [BYTE_W-1:0]    cur_byte;

  assign c        = q_rd.cmd;
  assign is_err   = (c.op == CMD_ERR);
  assign seg_a    = (c.op == CMD_HDR) ? POS_W'(2) : POS_W'(1);
  assign total    = seg_a + (c.do_vlen ? POS_W'(4) : '0) + (c.do_crc ? POS_W'(4) : '0);
  assign rel_v    = pos_r - seg_a;
  assign in_a     = (pos_r < seg_a);
  assign in_v     = !in_a && c.do_vlen && (rel_v < POS_W'(4));
  assign in_c     = !in_a && !in_v;
  assign rel_c    = c.do_vlen ? rel_v - POS_W'(4) : rel_v;
  assign last     = (pos_r == total - POS_W'(1));
  assign fire     = q_rd.valid && (!out_valid_r || out_ch.ready);
  assign q_pop    = fire && last;
  assign crc_out  = crc_r ^ CRC_ONES;
  assign crc_base = (c.op == CMD_HDR && pos_r == '0) ? CRC_ONES : crc_r;

  always_comb begin
    if (is_err) begin
      cur_byte = '0;
    end else if (in_a) begin
      cur_byte = (c.op == CMD_HDR && pos_r == POS_W'(1)) ? c.byte1 : c.byte0;
    end else if (in_v) begin
      cur_byte = c.vlen[{rel_v[1:0], 3'b000} +: BYTE_W];
    end else begin
      cur_byte = crc_out[{rel_c[1:0], 3'b000} +: BYTE_W];
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      pos_nxt       = last ? '0 : pos_r + POS_W'(1);
      if (!is_err) begin
        if (in_c) begin
          if (rel_c == POS_W'(3)) begin
            crc_nxt = CRC_ONES;
          end
        end else begin
          crc_nxt = crc_byte(crc_base, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r   <= cur_byte;
      byte_valid_r <= !is_err;
      last_r       <= last;
      done_r       <= !is_err && in_c && (rel_c == POS_W'(3));
      ofs_r        <= c.rec_ofs;
      err_r        <= is_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= CRC_ONES;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.byte_valid    = byte_valid_r;
  assign out_ch.last_in_run   = last_r;
  assign out_ch.record_done   = done_r;
  assign out_ch.record_offset = ofs_r;
  assign out_ch.error         = err_r;

endmodule

[rtl/crc_framed_record_writer.sv]
// ----------------------------------------------------------------------------
// CRC framed record writer
// Serializes key/value records as length-prefixed bytes closed by a CRC-32.
// ----------------------------------------------------------------------------
// The block emits one record byte per clock cycle while the output is ready.
// A payload item yields one byte, or up to nine when it closes the key or the
// value; a header item yields two to ten bytes. The front end accepts one
// item per cycle while its four-entry command queue has room, so payload
// bytes keep that rate while the output is ready. Out-of-order items give one
// error transfer and are dropped. A base offset write loads the running tail
// offset and is taken in any cycle.
// ----------------------------------------------------------------------------
`include "crc_framed_record_writer_macros.svh"

module crc_framed_record_writer import crc_frw_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  crc_frw_in_if.sink    in_ch,
  crc_frw_cfg_if.sink   cfg_ch,
  crc_frw_out_if.source out_ch
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  crc_frw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  crc_frw_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  crc_frw_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  `CFRW_ASSERT_IMP(a_done_is_last, out_ch.valid && out_ch.record_done,
                   out_ch.last_in_run && out_ch.byte_valid,
                   "Final CRC byte is not the last byte of its item.")
  `CFRW_ASSERT_IMP(a_err_single, out_ch.valid && out_ch.error,
                   out_ch.last_in_run && out_ch.out_byte == '0 && !out_ch.record_done,
                   "Error transfer is malformed.")
  `CFRW_ASSERT_NEVER(a_err_vs_valid, out_ch.valid && (out_ch.error == out_ch.byte_valid),
                     "Error and byte valid flags disagree.")

endmodule
